// ===== hw/rtl/cfs_pkg.sv =====
// Shared types, event codes and calendar limits for the calendar field setter.
package cfs_pkg;

	// Event codes carried in the input tuser.
	localparam logic [2:0] FUNC_NEXT  = 3'd0;
	localparam logic [2:0] FUNC_INC   = 3'd1;
	localparam logic [2:0] FUNC_DEC   = 3'd2;
	localparam logic [2:0] FUNC_COMMIT = 3'd3;
	localparam logic [2:0] FUNC_LEAVE = 3'd4;
	localparam logic [2:0] FUNC_LOAD  = 3'd5;

	// Field selector codes.
	localparam logic [2:0] SEL_NONE    = 3'd0;
	localparam logic [2:0] SEL_YEAR    = 3'd1;
	localparam logic [2:0] SEL_MONTH   = 3'd2;
	localparam logic [2:0] SEL_DAY     = 3'd3;
	localparam logic [2:0] SEL_HOUR    = 3'd4;
	localparam logic [2:0] SEL_MINUTE  = 3'd5;
	localparam logic [2:0] SEL_SECOND  = 3'd6;
	localparam logic [2:0] SEL_WEEKDAY = 3'd7;

	// Field limits.
	localparam logic [6:0] YEAR_MAX    = 7'd99;
	localparam logic [3:0] MONTH_MAX   = 4'd12;
	localparam logic [4:0] HOUR_MAX    = 5'd23;
	localparam logic [5:0] MINUTE_MAX  = 6'd59;
	localparam logic [5:0] SECOND_MAX  = 6'd59;
	localparam logic [2:0] WEEKDAY_MAX = 3'd7;
	localparam logic [6:0] YEAR_CENTURY = 7'd100;
	localparam logic [4:0] FEB_SHORT   = 5'd28;
	localparam logic [4:0] FEB_LONG    = 5'd29;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;

	// Calendar fields held by the editor.
	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [2:0] weekday;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
	} cal_t;

	// Days in the given month; months outside one to twelve count as 31 days.
	function automatic logic [4:0] month_days(input logic [3:0] month,
	                                          input logic [4:0] feb_days);
		logic [4:0] len;
		len = 5'd31;
		case (month) inside
			4'd2:                    len = feb_days;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== hw/rtl/calendar_field_setter_core.sv =====
// Top level of the calendar field setter: button-event editor for date and time.
//
// Usage: each input word on the s_ channel is one button event. Its kind travels in
// s_tuser (next field, increase, decrease, commit, leave, load) and the values to load
// travel in s_tdata; they are only used by a load event. Every event yields exactly one
// output word on the m_ channel that shows the whole editor state after the event:
// all seven calendar fields and the February length in m_tdata, the selected field and
// a commit flag in m_tuser.
//
// An accepted event waits in an input register and is then applied to the state
// registers, which double as the output register, so the result word is registered.
// The update itself is at most one compare-and-wrap on a single field, or a load of all
// fields, so one event is taken in every cycle while the receiver keeps m_tready high.
//
// When the receiver stalls, the shown result holds and one further event may still be
// taken into the input register; s_tready then drops until the result is taken.
//
// Reset clears the date to year 00, January the first, weekday one, time 00:00:00,
// with no field selected and February at 28 days; both channels start empty.
module calendar_field_setter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// year_in[6:0], month_in[10:7], date_in[15:11], weekday_in[18:16],
	// hour_in[23:19], minute_in[29:24], second_in[35:30], zero pad [39:36]
	input  logic [cfs_pkg::IN_DATA_W-1:0] s_tdata,
	// func[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// year[6:0], month[10:7], day_of_month[15:11], weekday[18:16], hour[23:19],
	// minute[29:24], second[35:30], feb_length[40:36], zero pad [47:41]
	output logic [cfs_pkg::OUT_DATA_W-1:0] m_tdata,
	// field_sel[2:0], commit_pulse[3]
	output logic [3:0]  m_tuser
);

	// Input register stage.
	logic             valid_s1;
	logic [2:0]       func_s1;
	cfs_pkg::cal_t    load_s1;

	// Editor state; it is also the result shown on the output.
	cfs_pkg::cal_t    cal_q;
	logic [2:0]       sel_q;
	logic [4:0]       feb_q;
	logic             commit_q;
	logic             out_valid_q;

	logic             advance;
	cfs_pkg::cal_t    cal_d;
	logic [2:0]       sel_d;
	logic [4:0]       feb_d;
	logic [4:0]       day_len;
	logic [6:0]       year_step;
	logic             leap;

	// The staged event moves on when the output word is free or being taken.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1         <= s_tuser;
			load_s1.year    <= s_tdata[6:0];
			load_s1.month   <= s_tdata[10:7];
			load_s1.day     <= s_tdata[15:11];
			load_s1.weekday <= s_tdata[18:16];
			load_s1.hour    <= s_tdata[23:19];
			load_s1.minute  <= s_tdata[29:24];
			load_s1.second  <= s_tdata[35:30];
		end
	end

	assign day_len = cfs_pkg::month_days(cal_q.month, feb_q);

	// Year step on its own, since February follows the stepped year.
	always_comb begin
		if (func_s1 == cfs_pkg::FUNC_INC) begin
			year_step = (cal_q.year >= cfs_pkg::YEAR_MAX) ? 7'd0 : cal_q.year + 7'd1;
		end else begin
			year_step = (cal_q.year == 7'd0) ? cfs_pkg::YEAR_MAX : cal_q.year - 7'd1;
		end
	end

	// A stepped year can reach 100 from a loaded value above it; that and 00 are
	// the only multiples of 100 a seven-bit year can hold, and neither is a leap year.
	assign leap = (year_step[1:0] == 2'd0) && (year_step != 7'd0)
	              && (year_step != cfs_pkg::YEAR_CENTURY);

	always_comb begin
		cal_d = cal_q;
		sel_d = sel_q;
		feb_d = feb_q;
		case (func_s1)
			cfs_pkg::FUNC_NEXT: begin
				sel_d = (sel_q == cfs_pkg::SEL_WEEKDAY) ? cfs_pkg::SEL_YEAR : sel_q + 3'd1;
			end
			cfs_pkg::FUNC_INC: begin
				case (sel_q)
					cfs_pkg::SEL_YEAR: begin
						cal_d.year = year_step;
						feb_d      = leap ? cfs_pkg::FEB_LONG : cfs_pkg::FEB_SHORT;
					end
					cfs_pkg::SEL_MONTH: cal_d.month = (cal_q.month >= cfs_pkg::MONTH_MAX)
						? 4'd1 : cal_q.month + 4'd1;
					cfs_pkg::SEL_DAY: cal_d.day = (cal_q.day >= day_len)
						? 5'd1 : cal_q.day + 5'd1;
					cfs_pkg::SEL_HOUR: cal_d.hour = (cal_q.hour >= cfs_pkg::HOUR_MAX)
						? 5'd0 : cal_q.hour + 5'd1;
					cfs_pkg::SEL_MINUTE: cal_d.minute = (cal_q.minute >= cfs_pkg::MINUTE_MAX)
						? 6'd0 : cal_q.minute + 6'd1;
					cfs_pkg::SEL_SECOND: cal_d.second = (cal_q.second >= cfs_pkg::SECOND_MAX)
						? 6'd0 : cal_q.second + 6'd1;
					cfs_pkg::SEL_WEEKDAY: cal_d.weekday =
						(cal_q.weekday >= cfs_pkg::WEEKDAY_MAX) ? 3'd1 : cal_q.weekday + 3'd1;
					default: ;
				endcase
			end
			cfs_pkg::FUNC_DEC: begin
				case (sel_q)
					cfs_pkg::SEL_YEAR: begin
						cal_d.year = year_step;
						feb_d      = leap ? cfs_pkg::FEB_LONG : cfs_pkg::FEB_SHORT;
					end
					cfs_pkg::SEL_MONTH: cal_d.month = (cal_q.month <= 4'd1)
						? cfs_pkg::MONTH_MAX : cal_q.month - 4'd1;
					cfs_pkg::SEL_DAY: cal_d.day = (cal_q.day <= 5'd1)
						? day_len : cal_q.day - 5'd1;
					cfs_pkg::SEL_HOUR: cal_d.hour = (cal_q.hour == 5'd0)
						? cfs_pkg::HOUR_MAX : cal_q.hour - 5'd1;
					cfs_pkg::SEL_MINUTE: cal_d.minute = (cal_q.minute == 6'd0)
						? cfs_pkg::MINUTE_MAX : cal_q.minute - 6'd1;
					cfs_pkg::SEL_SECOND: cal_d.second = (cal_q.second == 6'd0)
						? cfs_pkg::SECOND_MAX : cal_q.second - 6'd1;
					cfs_pkg::SEL_WEEKDAY: cal_d.weekday = (cal_q.weekday <= 3'd1)
						? cfs_pkg::WEEKDAY_MAX : cal_q.weekday - 3'd1;
					default: ;
				endcase
			end
			cfs_pkg::FUNC_LEAVE: sel_d = cfs_pkg::SEL_NONE;
			cfs_pkg::FUNC_LOAD:  cal_d = load_s1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.year    <= 7'd0;
			cal_q.month   <= 4'd1;
			cal_q.day     <= 5'd1;
			cal_q.weekday <= 3'd1;
			cal_q.hour    <= 5'd0;
			cal_q.minute  <= 6'd0;
			cal_q.second  <= 6'd0;
			sel_q         <= cfs_pkg::SEL_NONE;
			feb_q         <= cfs_pkg::FEB_SHORT;
			commit_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				cal_q    <= cal_d;
				sel_q    <= sel_d;
				feb_q    <= feb_d;
				commit_q <= (func_s1 == cfs_pkg::FUNC_COMMIT);
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, feb_q, cal_q.second, cal_q.minute, cal_q.hour,
	                   cal_q.weekday, cal_q.day, cal_q.month, cal_q.year};
	assign m_tuser  = {commit_q, sel_q};

endmodule
